// ----- rtl/aesp_pkg.sv -----
// shared types and constants for the escape sequence / sgr parser
// no dependencies
package aesp_pkg;

  localparam int MaxParamsDef = 16;
  localparam int NumW = 16;
  localparam logic [7:0] EscByte = 8'h1B;
  localparam logic [7:0] BelByte = 8'h07;
  localparam logic [7:0] BasicLevel = 8'd170;
  localparam logic [7:0] CubeStep = 8'd51;
  localparam logic [7:0] CubeSide = 8'd6;
  localparam logic [7:0] CubePlane = 8'd36;
  localparam logic [7:0] GreyStep = 8'd11;
  localparam logic [7:0] GreyBase = 8'd232;
  localparam logic [23:0] FgResetVal = 24'hFFFFFF;
  localparam logic [23:0] BgResetVal = 24'h000000;

  localparam logic [0:0] CfgRegFg = 1'b0;
  localparam logic [0:0] CfgRegBg = 1'b1;

  localparam logic [1:0] EvText = 2'd0;
  localparam logic [1:0] EvClrLine = 2'd1;
  localparam logic [1:0] EvClrScreen = 2'd2;

  typedef enum logic [2:0] {
    MODE_TEXT, MODE_ESC, MODE_CSI, MODE_CSI_SKIP, MODE_STR, MODE_STR_ESC
  } mode_t;

  typedef enum logic [2:0] {
    ST_IDLE, ST_WALK, ST_EMIT0, ST_EMIT1
  } ctl_state_t;

  // walk sub-step for 38/48 decoding
  typedef enum logic [2:0] {
    WK_CODE, WK_SUB, WK_R, WK_G, WK_B, WK_IDX
  } walk_t;

  typedef struct packed {
    logic [7:0] char_code;
    logic       chunk_end;
  } in_word_t;

  typedef struct packed {
    logic [1:0]  event_kind;
    logic [7:0]  out_char;
    logic [23:0] fg_rgb;
    logic [23:0] bg_rgb;
    logic        bold_on;
    logic        last_of_run;
  } out_word_t;

  // controller to datapath
  typedef struct packed {
    logic parse;     // run byte parser on held word
    logic walk_step; // one sgr parameter step
    logic fin;       // chunk end revert
    logic emit0;
    logic emit1;
  } dp_cmd_t;

  // datapath to controller
  typedef struct packed {
    logic need_walk;
    logic walk_done;
    logic [1:0] n_res;
  } dp_sts_t;

  function automatic logic [23:0] basic_color(input logic [2:0] c, input logic [7:0] lvl);
    basic_color = {c[0] ? lvl : 8'd0, c[1] ? lvl : 8'd0, c[2] ? lvl : 8'd0};
  endfunction

  function automatic logic [7:0] clamp8(input logic [NumW-1:0] v);
    clamp8 = (v > 16'd255) ? 8'hFF : v[7:0];
  endfunction

  // 256-color palette entry (index < 256 guaranteed by caller)
  function automatic logic [23:0] pal256(input logic [7:0] x);
    logic [7:0] o, q36, rem, q6, bi, r, g, b, gr;
    o = x - 8'd16;
    // cube coordinates by compare against plane and side multiples
    q36 = 8'd0;
    for (int k = 1; k < 6; k++)
      if (o >= 8'(CubePlane * k)) q36 = 8'(k);
    rem = o - 8'(q36 * CubePlane);
    q6 = 8'd0;
    for (int k = 1; k < 6; k++)
      if (rem >= 8'(CubeSide * k)) q6 = 8'(k);
    bi = rem - 8'(q6 * CubeSide);
    r = 8'(q36 * CubeStep);
    g = 8'(q6 * CubeStep);
    b = 8'(bi * CubeStep);
    gr = 8'((x - GreyBase) * GreyStep);
    if (x < 8'd8) pal256 = basic_color(x[2:0], BasicLevel);
    else if (x < 8'd16) pal256 = basic_color(x[2:0], 8'd255);
    else if (x < GreyBase) pal256 = {r, g, b};
    else pal256 = {gr, gr, gr};
  endfunction

endpackage

// ----- rtl/aesp_ram.sv -----
// generic single-port-write ram with registered read
// no dependencies
module aesp_ram #(
  parameter int Width = 16,
  parameter int Depth = 16
) (
  input  logic                     clk,
  input  logic                     we,
  input  logic [$clog2(Depth)-1:0] waddr,
  input  logic [Width-1:0]         wdata,
  input  logic [$clog2(Depth)-1:0] raddr,
  output logic [Width-1:0]         rdata
);
  logic [Width-1:0] mem [Depth];
  always_ff @(posedge clk) begin
    if (we) mem[waddr] <= wdata;
    rdata <= mem[raddr];
  end
endmodule

// ----- rtl/aesp_ctrl.sv -----
// controller fsm: sequences parse, sgr walk and result emission
// depends on aesp_pkg
module aesp_ctrl (
  input  logic              clk,
  input  logic              rst_n,
  input  logic              in_valid,
  output logic              in_stall,
  output logic              out_valid,
  input  logic              out_stall,
  output aesp_pkg::dp_cmd_t cmd,
  input  aesp_pkg::dp_sts_t sts
);
  import aesp_pkg::*;

  ctl_state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    in_stall = 1'b1;
    out_valid = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_stall = 1'b0;
        if (in_valid) begin
          cmd.parse = 1'b1;
          state_nxt = ST_WALK;
        end
      end
      ST_WALK: begin
        // parse result is registered; walk sgr list if one was applied
        if (sts.need_walk && !sts.walk_done) begin
          cmd.walk_step = 1'b1;
        end else if (sts.n_res != 2'd0) begin
          state_nxt = ST_EMIT0;
        end else begin
          cmd.fin = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      ST_EMIT0: begin
        out_valid = 1'b1;
        cmd.emit0 = 1'b1;
        if (!out_stall) begin
          if (sts.n_res == 2'd2) state_nxt = ST_EMIT1;
          else begin
            cmd.fin = 1'b1;
            state_nxt = ST_IDLE;
          end
        end
      end
      ST_EMIT1: begin
        out_valid = 1'b1;
        cmd.emit1 = 1'b1;
        if (!out_stall) begin
          cmd.fin = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    out_valid |-> in_stall) else $error("input taken while emitting");
  assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == ST_EMIT1) |-> (sts.n_res == 2'd2)) else $error("second word without cause");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.parse |=> (state_r == ST_WALK)) else $error("parse not followed by walk");
endmodule

// ----- rtl/aesp_dp.sv -----
// datapath: parser state, parameter store, sgr walk and result formatting
// depends on aesp_pkg and aesp_ram
module aesp_dp #(
  parameter int MaxParams = aesp_pkg::MaxParamsDef
) (
  input  logic               clk,
  input  logic               rst_n,
  input  aesp_pkg::in_word_t in_data,
  input  logic               cfg_we,
  input  logic               cfg_sel,
  input  logic [23:0]        cfg_data,
  input  aesp_pkg::dp_cmd_t  cmd,
  output aesp_pkg::dp_sts_t  sts,
  output aesp_pkg::out_word_t out_data
);
  import aesp_pkg::*;

  localparam int AW = $clog2(MaxParams);
  localparam int CW = AW + 1;

  logic [23:0] dflt_fg_r, dflt_bg_r;
  mode_t mode_r, mode_nxt;
  logic bel_r, bel_nxt;
  logic [NumW-1:0] acc_r, acc_nxt;
  logic pres_r, pres_nxt;
  logic [CW-1:0] cnt_r, cnt_nxt;
  logic [NumW-1:0] p0_r, p0_nxt; // copy of first parameter for clear events
  logic [23:0] fg_r, bg_r;
  logic bold_r;
  logic chunk_r;
  logic [1:0] nres_r, nres_nxt;
  logic [1:0] kind0_r, kind0_nxt;
  logic [7:0] ch0_r, ch0_nxt, ch1_r, ch1_nxt;
  logic sgr_r, sgr_nxt;

  // walk
  logic [CW-1:0] wi_r;
  walk_t wk_r;
  logic is_bg_r;
  logic [7:0] cr_r, cg_r;
  logic walk_done_r;

  logic ram_we;
  logic [AW-1:0] ram_waddr, ram_raddr;
  logic [NumW-1:0] ram_wdata, ram_rdata;

  aesp_ram #(.Width(NumW), .Depth(MaxParams)) u_ram (
    .clk(clk), .we(ram_we), .waddr(ram_waddr), .wdata(ram_wdata),
    .raddr(ram_raddr), .rdata(ram_rdata));

  logic [7:0] b;
  logic [NumW+3:0] prod;
  assign b = in_data.char_code;
  assign prod = acc_r * 4'd10 + {12'd0, b[3:0]};

  // byte parser
  always_comb begin
    logic push, csi_path;
    mode_nxt = mode_r; bel_nxt = bel_r; acc_nxt = acc_r; pres_nxt = pres_r;
    cnt_nxt = cnt_r; p0_nxt = p0_r; nres_nxt = 2'd0; kind0_nxt = EvText;
    ch0_nxt = b; ch1_nxt = b; sgr_nxt = 1'b0;
    push = 1'b0; csi_path = 1'b0;
    case (mode_r)
      MODE_TEXT: begin
        if (b == EscByte) mode_nxt = MODE_ESC;
        else nres_nxt = 2'd1;
      end
      MODE_ESC: begin
        mode_nxt = MODE_TEXT;
        if (b == "[") begin
          mode_nxt = MODE_CSI; cnt_nxt = '0; acc_nxt = '0; pres_nxt = 1'b0;
        end else if (b == "\\" || b == "N" || b == "O") begin
        end else if (b == "]" || b == "P" || b == "X" || b == "^" || b == "_") begin
          mode_nxt = MODE_STR; bel_nxt = (b == "]");
        end else begin
          ch0_nxt = EscByte;
          if (b == EscByte) begin
            mode_nxt = MODE_ESC; nres_nxt = 2'd1;
          end else nres_nxt = 2'd2;
        end
      end
      MODE_CSI, MODE_CSI_SKIP: csi_path = 1'b1;
      MODE_STR_ESC: begin
        if (b == "\\") begin
          mode_nxt = MODE_TEXT; bel_nxt = 1'b0;
        end else if (b == EscByte) mode_nxt = MODE_STR_ESC;
        else if (b == BelByte && bel_r) begin
          mode_nxt = MODE_TEXT; bel_nxt = 1'b0;
        end else mode_nxt = MODE_STR;
      end
      default: begin
        if (b == EscByte) mode_nxt = MODE_STR_ESC;
        else if (b == BelByte && bel_r) begin
          mode_nxt = MODE_TEXT; bel_nxt = 1'b0;
        end else mode_nxt = MODE_STR;
      end
    endcase
    if (csi_path) begin
      if (b == EscByte) mode_nxt = MODE_ESC;
      else if (b < 8'h20 || b >= 8'h7F) mode_nxt = MODE_TEXT;
      else if (b >= 8'h40) begin
        mode_nxt = MODE_TEXT;
        if (mode_r != MODE_CSI_SKIP) begin
          push = pres_r || (cnt_r != '0);
          if (b == "m") sgr_nxt = 1'b1;
          else if ((b == "K" || b == "J") && (cnt_r + CW'(push)) == CW'(1)
                   && (cnt_r == '0 ? (pres_r ? acc_r : '0) : p0_r) == NumW'(2)) begin
            nres_nxt = 2'd1; ch0_nxt = 8'd0;
            kind0_nxt = (b == "K") ? EvClrLine : EvClrScreen;
          end
        end
      end else if (mode_r == MODE_CSI_SKIP) begin
      end else if (b >= "0" && b <= "9") begin
        acc_nxt = (prod > 20'd65535) ? 16'hFFFF : prod[NumW-1:0];
        pres_nxt = 1'b1;
      end else if (b == ";") push = 1'b1;
      else mode_nxt = MODE_CSI_SKIP;
    end
    ram_we = 1'b0;
    ram_waddr = cnt_r[AW-1:0];
    ram_wdata = pres_r ? acc_r : '0;
    if (push) begin
      if (cnt_r < CW'(MaxParams)) begin
        ram_we = cmd.parse;
        cnt_nxt = cnt_r + 1'b1;
        if (cnt_r == '0) p0_nxt = ram_wdata;
      end
      acc_nxt = '0; pres_nxt = 1'b0;
    end
  end

  // walk: one parameter read per cycle, read data arrives in the following cycle
  logic [CW-1:0] wi_nxt;
  assign ram_raddr = wi_r[AW-1:0];
  logic rd_ok_r;

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      dflt_fg_r <= FgResetVal; dflt_bg_r <= BgResetVal;
      mode_r <= MODE_TEXT; bel_r <= 1'b0; acc_r <= '0; pres_r <= 1'b0; cnt_r <= '0;
      fg_r <= FgResetVal; bg_r <= BgResetVal; bold_r <= 1'b0;
      sgr_r <= 1'b0; nres_r <= 2'd0; walk_done_r <= 1'b1; rd_ok_r <= 1'b0;
      wi_r <= '0; wk_r <= WK_CODE;
    end else begin
      if (cfg_we) begin
        if (cfg_sel == CfgRegFg) dflt_fg_r <= cfg_data;
        else dflt_bg_r <= cfg_data;
      end
      if (cmd.parse) begin
        mode_r <= mode_nxt; bel_r <= bel_nxt; acc_r <= acc_nxt; pres_r <= pres_nxt;
        cnt_r <= cnt_nxt; p0_r <= p0_nxt; nres_r <= nres_nxt; kind0_r <= kind0_nxt;
        ch0_r <= ch0_nxt; ch1_r <= ch1_nxt; sgr_r <= sgr_nxt; chunk_r <= in_data.chunk_end;
        wi_r <= '0; wk_r <= WK_CODE; rd_ok_r <= 1'b0;
        walk_done_r <= 1'b0;
        if (sgr_nxt && cnt_nxt == '0) begin
          fg_r <= dflt_fg_r; bg_r <= dflt_bg_r; bold_r <= 1'b0;
          walk_done_r <= 1'b1;
        end
      end
      if (cmd.walk_step) begin
        if (!rd_ok_r) begin
          // first cycle: address 0 is presented, data valid next
          rd_ok_r <= 1'b1;
          wi_r <= wi_r + 1'b1;
        end else begin
          logic [NumW-1:0] c;
          c = ram_rdata;
          wi_r <= wi_r + 1'b1;
          case (wk_r)
            WK_CODE: begin
              if (c >= 16'd30 && c <= 16'd37) fg_r <= basic_color(c[2:0] - 3'd6, BasicLevel);
              else if (c >= 16'd40 && c <= 16'd47) bg_r <= basic_color(c[2:0], BasicLevel);
              else if (c == 16'd0) begin
                fg_r <= dflt_fg_r; bg_r <= dflt_bg_r; bold_r <= 1'b0;
              end else if (c == 16'd1) bold_r <= 1'b1;
              else if (c == 16'd39) fg_r <= dflt_fg_r;
              else if (c == 16'd49) bg_r <= dflt_bg_r;
              else if (c == 16'd38 || c == 16'd48) begin
                wk_r <= WK_SUB; is_bg_r <= (c == 16'd48);
              end
            end
            WK_SUB: begin
              if (c == 16'd2) wk_r <= WK_R;
              else if (c == 16'd5) wk_r <= WK_IDX;
              else wk_r <= WK_CODE;
            end
            WK_R: begin cr_r <= clamp8(c); wk_r <= WK_G; end
            WK_G: begin cg_r <= clamp8(c); wk_r <= WK_B; end
            WK_B: begin
              if (is_bg_r) bg_r <= {cr_r, cg_r, clamp8(c)};
              else fg_r <= {cr_r, cg_r, clamp8(c)};
              wk_r <= WK_CODE;
            end
            WK_IDX: begin
              if (c < 16'd256) begin
                if (is_bg_r) bg_r <= pal256(c[7:0]);
                else fg_r <= pal256(c[7:0]);
              end
              wk_r <= WK_CODE;
            end
            default: wk_r <= WK_CODE;
          endcase
          // truncated 38/48 lists simply run off the end
          if (wi_r == cnt_r) walk_done_r <= 1'b1;
        end
      end
      if (cmd.fin && chunk_r) begin
        fg_r <= dflt_fg_r; bg_r <= dflt_bg_r; bold_r <= 1'b0;
      end
    end
  end
  assign wi_nxt = wi_r;

  assign sts.need_walk = sgr_r;
  assign sts.walk_done = walk_done_r || (cnt_r == '0) || (wi_nxt > cnt_r);
  assign sts.n_res = nres_r;

  always_comb begin
    out_data.event_kind = cmd.emit1 ? EvText : kind0_r;
    out_data.out_char = cmd.emit1 ? ch1_r : ch0_r;
    out_data.fg_rgb = fg_r;
    out_data.bg_rgb = bg_r;
    out_data.bold_on = bold_r;
    out_data.last_of_run = cmd.emit1 || (nres_r == 2'd1);
  end

  assert property (@(posedge clk) disable iff (!rst_n)
    cnt_r <= CW'(MaxParams)) else $error("parameter count overflow");
  assert property (@(posedge clk) disable iff (!rst_n)
    (nres_r == 2'd2) |-> (kind0_r == EvText && ch0_r == EscByte))
    else $error("two results without stray escape");
  assert property (@(posedge clk) disable iff (!rst_n)
    cmd.walk_step |-> sgr_r) else $error("walk without sgr");
endmodule

// ----- rtl/ansi_escape_sgr_parser_top.sv -----
// ansi escape stripper with sgr color tracking, top level
// depends on aesp_pkg, aesp_ctrl, aesp_dp, aesp_ram
//
// input channel: one terminal byte plus chunk_end flag per word, valid/stall.
// output channel: text or clear events with the current colors and bold,
// valid/stall; last_of_run marks the final word caused by one input byte.
// a byte yields zero, one or two output words (stray escape gives two).
// sequence: accept and parse the byte, then an sgr final byte walks the stored
// parameter list at one entry per cycle, then each output word is presented
// in turn. each plain text byte passes the idle, walk and emit states.
// one byte is in flight at a time; in_stall is high until its words are taken.
// out_stall holds the presented word unchanged until taken.
// reset (rst_n low, synchronous) returns to text mode, colors to the
// register defaults (white on black), bold off; no clearing pass is needed.
// cfg writes (index 0 foreground, 1 background) are always ready and only
// change the defaults, not the current colors.
module ansi_escape_sgr_parser_top #(
  parameter int MaxParams = aesp_pkg::MaxParamsDef
) (
  input  logic                clk,
  input  logic                rst_n,
  input  logic                in_valid,
  output logic                in_stall,
  input  aesp_pkg::in_word_t  in_data,
  output logic                out_valid,
  input  logic                out_stall,
  output aesp_pkg::out_word_t out_data,
  input  logic                cfg_valid,
  output logic                cfg_ready,
  input  logic [0:0]          cfg_index,
  input  logic [23:0]         cfg_data
);
  import aesp_pkg::*;

  dp_cmd_t cmd;
  dp_sts_t sts;

  assign cfg_ready = 1'b1;

  aesp_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_valid(in_valid), .in_stall(in_stall),
    .out_valid(out_valid), .out_stall(out_stall), .cmd(cmd), .sts(sts));

  aesp_dp #(.MaxParams(MaxParams)) u_dp (
    .clk(clk), .rst_n(rst_n), .in_data(in_data),
    .cfg_we(cfg_valid && cfg_ready), .cfg_sel(cfg_index), .cfg_data(cfg_data),
    .cmd(cmd), .sts(sts), .out_data(out_data));
endmodule

// ----- tb/ansi_escape_sgr_parser_top_test.sv -----
// testbench for ansi_escape_sgr_parser_top: escape stripping, sgr colors, clear events
// depends on aesp_pkg and the rtl of the parser; self-contained predictor and scoreboard
module ansi_escape_sgr_parser_top_test;
  import aesp_pkg::*;

  localparam int WatchLimit = 3000;
  localparam int LongHold = 300;

  // predicts output words of the parser and checks them in order
  class sgr_scoreboard;
    mode_t mode;
    bit bel_end;
    int unsigned acc;
    bit have_num;
    int unsigned params[MaxParamsDef];
    int unsigned pcount;
    logic [23:0] fg, bg, dflt_fg, dflt_bg;
    bit bold;
    out_word_t pending[$];
    out_word_t words[$];
    int errors;

    function void init();
      dflt_fg = FgResetVal;
      dflt_bg = BgResetVal;
      mode = MODE_TEXT;
      bel_end = 0;
      acc = 0;
      have_num = 0;
      pcount = 0;
      foreach (params[i]) params[i] = 0;
      to_defaults();
      pending.delete();
      errors = 0;
    endfunction

    function void set_reg(logic [0:0] idx, logic [23:0] val);
      if (idx == CfgRegFg) dflt_fg = val;
      else dflt_bg = val;
    endfunction

    function void to_defaults();
      fg = dflt_fg;
      bg = dflt_bg;
      bold = 0;
    endfunction

    function logic [23:0] rgb(int unsigned r, int unsigned g, int unsigned b);
      if (r > 255) r = 255;
      if (g > 255) g = 255;
      if (b > 255) b = 255;
      return {r[7:0], g[7:0], b[7:0]};
    endfunction

    function logic [23:0] primary(int unsigned c, int unsigned lvl);
      return rgb(c[0] ? lvl : 0, c[1] ? lvl : 0, c[2] ? lvl : 0);
    endfunction

    function void emit(logic [1:0] kind, logic [7:0] ch);
      out_word_t w;
      w.event_kind = kind;
      w.out_char = ch;
      w.fg_rgb = fg;
      w.bg_rgb = bg;
      w.bold_on = bold;
      w.last_of_run = 0;
      words.push_back(w);
    endfunction

    function void push_num();
      if (pcount < MaxParamsDef) begin
        params[pcount] = have_num ? acc : 0;
        pcount++;
      end
      acc = 0;
      have_num = 0;
    endfunction

    function void apply_sgr();
      int unsigned i, c, sub, x, o, g;
      logic [23:0] col;
      bit hit;
      if (pcount == 0) begin
        to_defaults();
        return;
      end
      for (i = 0; i < pcount; i++) begin
        c = params[i];
        if (c >= 30 && c <= 37) fg = primary(c - 30, 170);
        else if (c >= 40 && c <= 47) bg = primary(c - 40, 170);
        else if (c == 0) to_defaults();
        else if (c == 1) bold = 1;
        else if (c == 39) fg = dflt_fg;
        else if (c == 49) bg = dflt_bg;
        else if (c == 38 || c == 48) begin
          hit = 0;
          col = 0;
          i++;
          if (i >= pcount) break;
          sub = params[i];
          if (sub == 2) begin
            if (i + 3 < pcount) begin
              col = rgb(params[i+1], params[i+2], params[i+3]);
              hit = 1;
            end
            i += 3;
          end else if (sub == 5) begin
            if (i + 1 < pcount) begin
              x = params[i+1];
              hit = 1;
              if (x < 8) col = primary(x, 170);
              else if (x < 16) col = primary(x - 8, 255);
              else if (x < 232) begin
                o = x - 16;
                col = rgb((o / 36) * 51, ((o / 6) % 6) * 51, (o % 6) * 51);
              end else if (x < 256) begin
                g = (x - 232) * 11;
                col = rgb(g, g, g);
              end else hit = 0;
            end
            i++;
          end
          if (hit) begin
            if (c == 38) fg = col;
            else bg = col;
          end
        end
      end
    endfunction

    function void text_char(logic [7:0] b);
      if (b == EscByte) mode = MODE_ESC;
      else emit(EvText, b);
    endfunction

    function void csi_char(logic [7:0] b);
      bit skip;
      if (b == EscByte) begin
        mode = MODE_ESC;
      end else if (b < 8'h20 || b >= 8'h7F) begin
        mode = MODE_TEXT;
      end else if (b >= 8'h40) begin
        skip = (mode == MODE_CSI_SKIP);
        mode = MODE_TEXT;
        if (!skip) begin
          if (have_num || pcount > 0) push_num();
          if (b == "m") apply_sgr();
          else if ((b == "K" || b == "J") && pcount == 1 && params[0] == 2)
            emit(b == "K" ? EvClrLine : EvClrScreen, 8'd0);
        end
      end else if (mode != MODE_CSI_SKIP) begin
        if (b >= "0" && b <= "9") begin
          acc = acc * 10 + (b - "0");
          if (acc > 65535) acc = 65535;
          have_num = 1;
        end else if (b == ";") push_num();
        else mode = MODE_CSI_SKIP;
      end
    endfunction

    function void note_input(in_word_t w);
      logic [7:0] b;
      b = w.char_code;
      words.delete();
      case (mode)
        MODE_TEXT: text_char(b);
        MODE_ESC: begin
          mode = MODE_TEXT;
          if (b == "[") begin
            mode = MODE_CSI;
            pcount = 0;
            acc = 0;
            have_num = 0;
          end else if (b == "\\" || b == "N" || b == "O") begin
          end else if (b == "]" || b == "P" || b == "X" || b == "^" || b == "_") begin
            mode = MODE_STR;
            bel_end = (b == "]");
          end else begin
            emit(EvText, EscByte);
            text_char(b);
          end
        end
        MODE_CSI, MODE_CSI_SKIP: csi_char(b);
        default: begin
          if (mode == MODE_STR_ESC && b == "\\") begin
            mode = MODE_TEXT;
            bel_end = 0;
          end else if (b == EscByte) mode = MODE_STR_ESC;
          else if (b == BelByte && bel_end) begin
            mode = MODE_TEXT;
            bel_end = 0;
          end else mode = MODE_STR;
        end
      endcase
      if (words.size() > 0) words[words.size()-1].last_of_run = 1;
      foreach (words[i]) pending.push_back(words[i]);
      if (w.chunk_end) to_defaults();
    endfunction

    function void check(out_word_t got);
      out_word_t exp_w;
      bit ok;
      if (pending.size() == 0) begin
        errors++;
        if (errors <= 10) $display("unexpected word %h", got);
        return;
      end
      exp_w = pending.pop_front();
      ok = exp_w.event_kind == got.event_kind && exp_w.out_char == got.out_char &&
           exp_w.fg_rgb == got.fg_rgb && exp_w.bg_rgb == got.bg_rgb &&
           exp_w.bold_on == got.bold_on && exp_w.last_of_run == got.last_of_run;
      if (!ok) begin
        errors++;
        if (errors <= 10)
          $display("mismatch: kind %0d/%0d char %h/%h fg %h/%h bg %h/%h bold %b/%b last %b/%b",
                   exp_w.event_kind, got.event_kind, exp_w.out_char, got.out_char,
                   exp_w.fg_rgb, got.fg_rgb, exp_w.bg_rgb, got.bg_rgb,
                   exp_w.bold_on, got.bold_on, exp_w.last_of_run, got.last_of_run);
      end
    endfunction
  endclass

  logic clk = 0;
  logic rst_n = 0;
  logic in_valid = 0;
  logic in_stall;
  in_word_t in_data = '0;
  logic out_valid;
  logic out_stall = 0;
  out_word_t out_data;
  logic cfg_valid = 0;
  logic cfg_ready;
  logic [0:0] cfg_index = CfgRegFg;
  logic [23:0] cfg_data = '0;

  sgr_scoreboard sb;
  bit quiet = 0;
  bit hold_req = 0;
  int bytes_sent = 0;
  int idle_cycles = 0;

  ansi_escape_sgr_parser_top uut (
    .clk(clk), .rst_n(rst_n),
    .in_valid(in_valid), .in_stall(in_stall), .in_data(in_data),
    .out_valid(out_valid), .out_stall(out_stall), .out_data(out_data),
    .cfg_valid(cfg_valid), .cfg_ready(cfg_ready), .cfg_index(cfg_index),
    .cfg_data(cfg_data)
  );

  always begin
    #5 clk = 1;
    #5 clk = 0;
  end

  // result side checking and watchdog
  always @(posedge clk) begin
    if (rst_n && out_valid && !out_stall) sb.check(out_data);
    if ((in_valid && !in_stall) || (out_valid && !out_stall) || (cfg_valid && cfg_ready)
        || !rst_n)
      idle_cycles <= 0;
    else
      idle_cycles <= idle_cycles + 1;
    if (idle_cycles >= WatchLimit) begin
      $display("[ansi_escape_sgr_parser_top] ERROR");
      $finish;
    end
  end

  // receiver stalls, with one long hold-off on request
  initial begin
    @(posedge rst_n);
    forever begin
      @(posedge clk);
      if (hold_req) begin
        hold_req = 0;
        out_stall <= 1;
        repeat (LongHold) @(posedge clk);
        out_stall <= 0;
      end else if (!quiet && $urandom_range(0, 7) == 0) begin
        out_stall <= 1;
        repeat ($urandom_range(1, 14)) @(posedge clk);
        out_stall <= 0;
      end
    end
  end

  task automatic send_byte(logic [7:0] b, bit ce);
    in_word_t w;
    w.char_code = b;
    w.chunk_end = ce;
    in_data <= w;
    in_valid <= 1;
    do @(posedge clk); while (in_stall);
    sb.note_input(w);
    bytes_sent++;
    if (!quiet && $urandom_range(0, 7) == 0) begin
      in_valid <= 0;
      repeat ($urandom_range(1, 14)) @(posedge clk);
    end
  endtask

  task automatic send_str(string s, bit ce_last);
    for (int i = 0; i < s.len(); i++)
      send_byte(s[i], ce_last && i == s.len() - 1);
  endtask

  task automatic drain();
    in_valid <= 0;
    @(posedge clk);
    while (sb.pending.size() != 0) @(posedge clk);
    // a byte with no word may still be walking its parameter list
    repeat (40) @(posedge clk);
  endtask

  task automatic write_reg(logic [0:0] idx, logic [23:0] val);
    cfg_index <= idx;
    cfg_data <= val;
    cfg_valid <= 1;
    do @(posedge clk); while (!cfg_ready);
    cfg_valid <= 0;
    sb.set_reg(idx, val);
  endtask

  function automatic int unsigned pick_param();
    case ($urandom_range(0, 11))
      0: return 0;
      1: return 1;
      2: return $urandom_range(30, 37);
      3: return $urandom_range(40, 47);
      4: return 39;
      5: return 49;
      6: return 38;
      7: return 48;
      8: return 2;
      9: return 5;
      10: return $urandom_range(0, 300);
      default: return $urandom_range(0, 99999);
    endcase
  endfunction

  task automatic random_sequence();
    string s;
    int n;
    bit ce;
    ce = ($urandom_range(0, 15) == 0);
    case ($urandom_range(0, 9))
      0, 1: begin
        // well-formed sgr with random parameters, sometimes overlong
        n = ($urandom_range(0, 9) == 0) ? $urandom_range(14, 20) : $urandom_range(0, 6);
        s = "\033[";
        for (int i = 0; i < n; i++) begin
          if ($urandom_range(0, 11) != 0) s = {s, $sformatf("%0d", pick_param())};
          if (i != n - 1) s = {s, ";"};
        end
        send_str({s, "m"}, ce);
      end
      2: begin
        if ($urandom_range(0, 1)) s = $sformatf("\033[38;2;%0d;%0d;%0dm",
          $urandom_range(0, 400), $urandom_range(0, 400), $urandom_range(0, 400));
        else s = $sformatf("\033[%0d;5;%0dm", $urandom_range(0, 1) ? 38 : 48,
          $urandom_range(0, 270));
        send_str(s, ce);
      end
      3: send_str($urandom_range(0, 1) ? "\033[2K" : "\033[2J", ce);
      4: begin
        s = $urandom_range(0, 1) ? "\033]" : "\033P";
        repeat ($urandom_range(0, 5))
          s = $sformatf("%s%c", s, 8'($urandom_range(8'h20, 8'h7E)));
        if ($urandom_range(0, 3) == 0) s = {s, "\033a"};
        if (s[1] == "]" && $urandom_range(0, 1)) s = {s, "\007"};
        else s = {s, "\033\\"};
        send_str(s, ce);
      end
      5: begin
        // csi with random body, may be private, aborted or any final
        s = "\033[";
        repeat ($urandom_range(0, 4))
          s = $sformatf("%s%c", s, 8'($urandom_range(8'h20, 8'h3F)));
        send_str(s, 0);
        send_byte(8'($urandom_range(0, 255)), ce);
      end
      6: begin
        send_byte(EscByte, 0);
        send_byte(8'($urandom_range(0, 255)), ce);
      end
      default: repeat ($urandom_range(1, 6)) send_byte(8'($urandom_range(0, 255)), ce);
    endcase
  endtask

  initial begin
    logic [23:0] fg_set[4];
    logic [23:0] bg_set[4];
    sb = new();
    sb.init();
    fg_set = '{24'hFFFFFF, 24'h000000, 24'hFFFFFF, 24'h000000};
    bg_set = '{24'h000000, 24'hFFFFFF, 24'h000000, 24'h000000};
    fg_set[2] = 24'($urandom_range(0, 24'hFFFFFF));
    bg_set[2] = 24'($urandom_range(0, 24'hFFFFFF));
    repeat (6) @(posedge clk);
    rst_n <= 1;
    @(posedge clk);

    // directed part
    send_byte(8'h00, 0);
    send_byte(8'hFF, 0);
    send_str("\033[1;31;42mA\033[38;2;300;0;128;48;5;9mB", 0);
    send_str("\033[38;5;100;48;5;240mC\033[38;5;300;48;2;1m", 0);
    send_str("\033[2K\033[2J\033[;2K\033[?25h\033[99999;;m", 0);
    send_str("\033]t\033x\007\033Pq\033\\\033N\033O\033z\033\033[m", 0);
    send_str("\033[1;2;3;4;5;6;7;8;9;10;11;12;13;14;15;16;31mD\033[3\001E", 1);
    send_byte("F", 0);

    for (int ph = 0; ph < 4; ph++) begin
      drain();
      write_reg(CfgRegFg, fg_set[ph]);
      write_reg(CfgRegBg, bg_set[ph]);
      if (ph == 1) hold_req = 1;
      if (ph == 3) quiet = 1;
      while (bytes_sent < 90 + (ph + 1) * 140) random_sequence();
    end

    in_valid <= 0;
    while (sb.pending.size() != 0) @(posedge clk);
    repeat (50) @(posedge clk);
    if (sb.errors == 0 && sb.pending.size() == 0)
      $display("[ansi_escape_sgr_parser_top] OK");
    else
      $display("[ansi_escape_sgr_parser_top] ERROR");
    $finish;
  end

endmodule
